// ----- rtl/core/sort_order_detector_assert.svh -----
// Assertion macros for the sort order detector
`ifndef SORT_ORDER_DETECTOR_ASSERT_SVH
`define SORT_ORDER_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
// check outside reset
`define SOD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check on every edge, reset included
`define SOD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SOD_ASSERT(lbl, prop, msg)
`define SOD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/sod_pkg.sv -----
// Shared types and constants for the sort order detector
`timescale 1ns / 1ps
package sod_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH     = 32;
  localparam int ORDER_COUNT     = 8;
  localparam int CODE_WIDTH      = 3;
  localparam logic [ORDER_COUNT-1:0] ALIVE_RESET = 8'hFF;
  localparam logic [CODE_WIDTH-1:0]  CODE_2D_UP   = 3'd4;
  localparam logic [CODE_WIDTH-1:0]  CODE_2D_DOWN = 3'd6;

  // previous pair against current pair, signed
  typedef struct packed {
    logic line_lt;
    logic line_eq;
    logic line_gt;
    logic trace_lt;
    logic trace_eq;
    logic trace_gt;
  } cmp_t;

  typedef struct packed {
    logic store;
    logic decided;
    logic inconsistent;
  } upd_t;
endpackage

// ----- rtl/core/sod_compare.sv -----
// Signed compares of the previous coordinate pair against the current one
`timescale 1ns / 1ps
module sod_compare #(
  parameter int COORD_WIDTH = sod_pkg::COORD_WIDTH_DEF
) (
  input  logic [COORD_WIDTH-1:0] prev_line,
  input  logic [COORD_WIDTH-1:0] prev_trace,
  input  logic [COORD_WIDTH-1:0] cur_line,
  input  logic [COORD_WIDTH-1:0] cur_trace,
  output sod_pkg::cmp_t          cmp
);
  always_comb begin
    cmp.line_lt  = $signed(prev_line) < $signed(cur_line);
    cmp.line_eq  = prev_line == cur_line;
    cmp.line_gt  = $signed(prev_line) > $signed(cur_line);
    cmp.trace_lt = $signed(prev_trace) < $signed(cur_trace);
    cmp.trace_eq = prev_trace == cur_trace;
    cmp.trace_gt = $signed(prev_trace) > $signed(cur_trace);
  end
endmodule

// ----- rtl/core/sod_update.sv -----
// Candidate pruning, restore on no survivor, and order code selection
`timescale 1ns / 1ps
module sod_update (
  input  sod_pkg::cmp_t                         cmp,
  input  logic [sod_pkg::ORDER_COUNT-1:0]       alive,
  input  logic                                  two_d_mode,
  input  logic                                  line_undefined,
  input  logic                                  trace_undefined,
  input  logic                                  prev_line_known,
  input  logic                                  prev_trace_known,
  output sod_pkg::upd_t                         upd,
  output logic [sod_pkg::ORDER_COUNT-1:0]       alive_next,
  output logic [sod_pkg::CODE_WIDTH-1:0]        order_code
);
  logic [sod_pkg::ORDER_COUNT-1:0] fit_all;
  logic [sod_pkg::ORDER_COUNT-1:0] fit_mask;
  logic [sod_pkg::ORDER_COUNT-1:0] highest;
  logic                            learn;
  logic                            single;

  // each order code: bit 2 crossline-major, bit 1 crosslines descend, bit 0 inlines descend
  always_comb begin
    logic [sod_pkg::CODE_WIDTH-1:0] c;
    logic l_lt;
    logic t_lt;
    for (int i = 0; i < sod_pkg::ORDER_COUNT; i++) begin
      c    = sod_pkg::CODE_WIDTH'(i);
      l_lt = c[0] ? cmp.line_gt : cmp.line_lt;
      t_lt = c[1] ? cmp.trace_gt : cmp.trace_lt;
      if (c[2]) begin
        fit_all[i] = t_lt || (cmp.trace_eq && (l_lt || cmp.line_eq));
      end else begin
        fit_all[i] = l_lt || (cmp.line_eq && (t_lt || cmp.trace_eq));
      end
    end
  end

  // highest live candidate, kept when nothing survives
  always_comb begin
    highest = '0;
    for (int i = 0; i < sod_pkg::ORDER_COUNT; i++) begin
      if (alive[i]) begin
        highest = sod_pkg::ORDER_COUNT'(1) << i;
      end
    end
  end

  assign fit_mask = trace_undefined ? '0 : (alive & fit_all);
  assign single   = $onehot(fit_mask);
  assign learn    = cmp.line_eq && (trace_undefined || !cmp.trace_eq);

  always_comb begin
    upd        = '0;
    alive_next = alive;
    priority if (line_undefined) begin
      upd = '0;
    end else if (!prev_line_known || !prev_trace_known) begin
      upd.store = 1'b1;
    end else if (two_d_mode) begin
      upd.store = 1'b1;
      if (learn) begin
        upd.decided   = 1'b1;
        alive_next[0] = trace_undefined || cmp.trace_lt;
      end
    end else if (fit_mask == '0) begin
      upd.inconsistent = 1'b1;
      alive_next       = highest;
    end else begin
      upd.store   = 1'b1;
      upd.decided = single;
      alive_next  = fit_mask;
    end
  end

  always_comb begin
    order_code = '0;
    if (two_d_mode) begin
      order_code = alive_next[0] ? sod_pkg::CODE_2D_UP : sod_pkg::CODE_2D_DOWN;
    end else begin
      for (int i = sod_pkg::ORDER_COUNT - 1; i >= 0; i--) begin
        if (alive_next[i]) begin
          order_code = sod_pkg::CODE_WIDTH'(i);
        end
      end
    end
  end
endmodule

// ----- rtl/core/sort_order_detector.sv -----
// Sort order detector: narrows eight candidate sort orders over a coordinate stream
// Input stream s_axis: one word per trace, carrying the line and trace numbers
// and their undefined flags. Output stream m_axis: one word per input word,
// in order, with the decided and inconsistent flags, the order code (in 3-D
// mode the lowest live one) and the live candidate mask after that trace.
// cfg_wen/cfg_wdata write the mode bit (1 = 2-D line/trace, 0 = 3-D); write
// it only while no word is in flight. It does not clear the candidate state.
// Flow: a word accepted into the input register is evaluated against the stored
// previous pair and moves into the output register once that register is free
// or its word is being taken; its result is then offered on m_axis.
// Throughput: one word per cycle while m_axis_tready stays high; the input register
// and the output register each hold one word, and the candidate state loops back
// through one compare pair and the pruning logic combinationally.
// Reset (rst, synchronous) empties both registers, marks the previous pair as
// unknown, sets all eight candidates live and selects 3-D mode.
// When m_axis_tready is low the output word holds; one more word is taken
// into the input register, then s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps
module sort_order_detector #(
  parameter int COORD_WIDTH = sod_pkg::COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,      // two_d_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] line_number, [63:32] trace_number
  input  logic [1:0]  s_axis_tuser,   // [0] line_undefined, [1] trace_undefined
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] order_code, [10:3] alive_mask, zero above
  output logic [1:0]  m_axis_tuser    // [0] decided, [1] inconsistent
);
  localparam int FW = sod_pkg::FIELD_WIDTH;
  localparam int NO = sod_pkg::ORDER_COUNT;
  localparam int CW = sod_pkg::CODE_WIDTH;

  logic                   two_d_mode;
  logic                   in_valid;
  logic [COORD_WIDTH-1:0] in_line;
  logic [COORD_WIDTH-1:0] in_trace;
  logic                   in_ludf;
  logic                   in_tudf;
  logic [COORD_WIDTH-1:0] prev_line;
  logic [COORD_WIDTH-1:0] prev_trace;
  logic                   prev_line_known;
  logic                   prev_trace_known;
  logic [NO-1:0]          alive;
  logic [NO-1:0]          alive_next;
  logic [CW-1:0]          code_next;
  logic                   out_valid;
  logic                   out_decided;
  logic                   out_incons;
  logic [CW-1:0]          out_code;
  logic [NO-1:0]          out_alive;
  logic                   advance;
  sod_pkg::cmp_t          cmp;
  sod_pkg::upd_t          upd;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      two_d_mode <= 1'b0;
    end else if (cfg_wen) begin
      two_d_mode <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_line  <= s_axis_tdata[COORD_WIDTH-1:0];
      in_trace <= s_axis_tdata[FW +: COORD_WIDTH];
      in_ludf  <= s_axis_tuser[0];
      in_tudf  <= s_axis_tuser[1];
    end
  end

  sod_compare #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_compare (
    .prev_line  (prev_line),
    .prev_trace (prev_trace),
    .cur_line   (in_line),
    .cur_trace  (in_trace),
    .cmp        (cmp)
  );

  sod_update u_update (
    .cmp              (cmp),
    .alive            (alive),
    .two_d_mode       (two_d_mode),
    .line_undefined   (in_ludf),
    .trace_undefined  (in_tudf),
    .prev_line_known  (prev_line_known),
    .prev_trace_known (prev_trace_known),
    .upd              (upd),
    .alive_next       (alive_next),
    .order_code       (code_next)
  );

  // candidate state and previous pair
  always_ff @(posedge clk) begin
    if (rst) begin
      alive            <= sod_pkg::ALIVE_RESET;
      prev_line_known  <= 1'b0;
      prev_trace_known <= 1'b0;
    end else if (advance) begin
      alive <= alive_next;
      if (upd.store) begin
        prev_line_known  <= 1'b1;
        prev_trace_known <= !in_tudf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && upd.store) begin
      prev_line  <= in_line;
      prev_trace <= in_tudf ? '0 : in_trace;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_decided <= upd.decided;
      out_incons  <= upd.inconsistent;
      out_code    <= code_next;
      out_alive   <= alive_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_alive, out_code};
  assign m_axis_tuser  = {out_incons, out_decided};

`include "sort_order_detector_assert.svh"

  `SOD_ASSERT(a_flags_exclusive, out_valid |-> !(out_decided && out_incons), "both flags set")
  `SOD_ASSERT(a_incons_restore, out_valid && out_incons |-> $onehot0(out_alive), "bad restore")
  `SOD_ASSERT_ALWAYS(a_reset_state, rst |=> (alive == sod_pkg::ALIVE_RESET) && !prev_line_known, "reset state")
  `SOD_ASSERT(a_incons_no_store, advance && upd.inconsistent |=> $stable(prev_line) && $stable(prev_trace), "pair moved")
endmodule
